// ===== rtl/frame_dc_removal_peak_normalize_core_macros.svh =====
// Assertion macros used by the port-level checker of the normalize core.
`ifndef FRAME_DC_REMOVAL_PEAK_NORMALIZE_CORE_MACROS_SVH
`define FRAME_DC_REMOVAL_PEAK_NORMALIZE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define FDPN_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fdpn assertion failed");

// Next-cycle implication, disabled while reset is low.
`define FDPN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fdpn assertion failed");

`endif

// ===== rtl/fdpn_pkg.sv =====
// Package: sizes, types and constants of the frame normalize core.
package fdpn_pkg;

    localparam int FRAME_LEN = 1024;
    localparam int SMP_W     = 16;
    localparam int IDX_W     = $clog2(FRAME_LEN);
    localparam int ADDR_W    = $clog2(2 * FRAME_LEN);
    localparam int SUM_W     = 17 + $clog2(FRAME_LEN);
    localparam int NUM_W     = SUM_W + 2;
    localparam int NMUL_W    = $clog2(FRAME_LEN + 1);
    localparam int DEN_W     = NMUL_W + 16;
    localparam int Q_W       = 17;
    localparam int CNT_W     = $clog2(Q_W + 1);

    localparam logic [Q_W-1:0]   Q_POS_MAX = Q_W'(32767);
    localparam logic [Q_W-1:0]   Q_NEG_LIM = Q_W'(32768);
    localparam logic [SMP_W-1:0] RES_POS_SAT = 16'h7FFF;
    localparam logic [SMP_W-1:0] RES_NEG_SAT = 16'h8000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_LOAD,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [IDX_W-1:0]        idx;
        logic                    bank;
        logic                    last;
        logic                    ready;
        logic signed [SUM_W-1:0] held_sum;
        logic [SMP_W-1:0]        held_peak;
    } t_frame_info;

endpackage

// ===== rtl/fdpn_frame_ram.sv =====
// Two-bank frame store: one write port, one registered read port.
module fdpn_frame_ram
    import fdpn_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [SMP_W-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [SMP_W-1:0]  o_rd_data
);

    logic [SMP_W-1:0] r_mem [2*FRAME_LEN];
    logic [SMP_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/fdpn_stats.sv =====
// Frame bookkeeping: position, bank, running and held sum and peak.
module fdpn_stats
    import fdpn_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  logic signed [SMP_W-1:0] i_sample,
    output t_frame_info             o_info
);

    logic [IDX_W-1:0]        r_idx;
    logic                    r_bank;
    logic                    r_ready;
    logic signed [SUM_W-1:0] r_run_sum;
    logic [SMP_W-1:0]        r_run_peak;
    logic signed [SUM_W-1:0] r_held_sum;
    logic [SMP_W-1:0]        r_held_peak;

    logic                    last;
    logic [SMP_W-1:0]        mag;
    logic signed [SUM_W-1:0] n_sum;
    logic [SMP_W-1:0]        n_peak;

    always_comb begin
        last   = (r_idx == IDX_W'(FRAME_LEN - 1));
        // -(-32768) wraps to 0x8000, read unsigned as 32768
        mag    = i_sample[SMP_W-1] ? SMP_W'(-i_sample) : i_sample;
        n_sum  = r_run_sum + {{(SUM_W-SMP_W){i_sample[SMP_W-1]}}, i_sample};
        n_peak = (mag > r_run_peak) ? mag : r_run_peak;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_bank      <= 1'b0;
            r_ready     <= 1'b0;
            r_run_sum   <= '0;
            r_run_peak  <= '0;
            r_held_sum  <= '0;
            r_held_peak <= '0;
        end else if (i_accept) begin
            if (last) begin
                r_held_sum  <= n_sum;
                r_held_peak <= n_peak;
                r_run_sum   <= '0;
                r_run_peak  <= '0;
                r_bank      <= ~r_bank;
                r_ready     <= 1'b1;
                r_idx       <= '0;
            end else begin
                r_run_sum   <= n_sum;
                r_run_peak  <= n_peak;
                r_idx       <= r_idx + 1'b1;
            end
        end
    end

    assign o_info = '{idx: r_idx, bank: r_bank, last: last, ready: r_ready,
                      held_sum: r_held_sum, held_peak: r_held_peak};

endmodule

// ===== rtl/fdpn_divider.sv =====
// Serial restoring divider, one quotient bit per cycle, Q1.15 saturation.
module fdpn_divider
    import fdpn_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0]        i_den,
    output logic                    o_done,
    output logic signed [SMP_W-1:0] o_result
);

    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [Q_W-1:0]   r_low;
    logic [Q_W-1:0]   r_q;
    logic [CNT_W-1:0] r_cnt;
    logic             r_neg;
    logic             r_zero;
    logic             r_done;

    logic [NUM_W-1:0] mag;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    always_comb begin
        mag   = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
        trial = {r_rem, r_low[Q_W-1]};
        diff  = trial - {1'b0, r_den};
        ge    = (trial >= {1'b0, r_den});
    end

    // Dividend is mag * 2^15; quotient stays below 2^17, so mag >> 2 < den
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_rem  <= mag[DEN_W+1:2];
            r_low  <= {mag[1:0], 15'b0};
            r_q    <= '0;
            r_den  <= i_den;
            r_neg  <= i_num[NUM_W-1];
            r_zero <= (i_den == '0);
            r_cnt  <= CNT_W'(Q_W);
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CNT_W'(1));
            if (r_cnt != '0) begin
                r_rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                r_q   <= {r_q[Q_W-2:0], ge};
                r_low <= {r_low[Q_W-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_comb begin
        if (r_zero) begin
            o_result = '0;
        end else if (r_neg) begin
            o_result = (r_q >= Q_NEG_LIM) ? RES_NEG_SAT : SMP_W'(Q_W'(0) - r_q);
        end else begin
            o_result = (r_q >= Q_POS_MAX) ? RES_POS_SAT : r_q[SMP_W-1:0];
        end
    end

    assign o_done = r_done;

endmodule

// ===== rtl/frame_dc_removal_peak_normalize_core.sv =====
// Top level: frame DC removal and peak normalization, one frame of delay.
// Usage
//   Input word: i_sample, taken when i_valid is high and o_stall is low.
//   Output word: o_normalized (signed Q1.15) and o_frame_end, taken when
//   o_valid is high and i_stall is low. Samples form frames of FRAME_LEN;
//   the sample at position i of frame k+1 releases the result for position
//   i of frame k: (x - mean) / peak, saturated, 0 for an all-zero frame.
//   The first frame after reset yields no words; its samples only load.
// Sequence
//   A sample that yields a result holds o_stall high through ST_MUL (store
//   data and N*x - S), ST_LOAD (divider load), ST_DIV (the quotient bits
//   and the done cycle) and ST_OUT (output load, which waits while a held
//   output word is stalled). The result is registered in the output word
//   as ST_OUT ends; no new sample is taken before then, so the serial
//   divider sets the rate. A first-frame sample is taken with no stall.
// Reset and stall
//   Synchronous active-low reset clears position, bank, sums, peaks and the
//   frame-held flag; the store is not cleared (every entry read was written
//   the frame before). While i_stall holds, the output word stays put; the
//   next sample is still taken and its result waits in the divider.
module frame_dc_removal_peak_normalize_core
    import fdpn_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [SMP_W-1:0] i_sample,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [SMP_W-1:0] o_normalized,
    output logic                    o_frame_end
);

    localparam logic signed [NUM_W-1:0] N_NUM = NUM_W'(FRAME_LEN);
    localparam logic [DEN_W-1:0]        N_DEN = DEN_W'(FRAME_LEN);

    t_state                  r_state, n_state;
    t_frame_info             info;
    logic                    in_accept;
    logic [ADDR_W-1:0]       wr_addr;
    logic [ADDR_W-1:0]       rd_addr;
    logic [SMP_W-1:0]        rd_data;

    // operands captured at acceptance, before the held values move on; num in ST_MUL
    logic signed [SUM_W-1:0] r_sum;
    logic [DEN_W-1:0]        r_den;
    logic                    r_last;
    logic signed [NUM_W-1:0] r_num;
    logic signed [NUM_W-1:0] n_num;

    logic                    div_start;
    logic                    div_done;
    logic signed [SMP_W-1:0] div_result;

    logic                    out_load;
    logic                    r_out_valid;
    logic signed [SMP_W-1:0] r_out_norm;
    logic                    r_out_end;

    assign in_accept = i_valid && !o_stall;

    fdpn_stats u_stats (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_sample (i_sample),
        .o_info   (info)
    );

    // loading bank written, the other bank (ready frame) read, same position
    always_comb begin
        wr_addr = info.bank ? ADDR_W'(info.idx) + ADDR_W'(FRAME_LEN) : ADDR_W'(info.idx);
        rd_addr = info.bank ? ADDR_W'(info.idx) : ADDR_W'(info.idx) + ADDR_W'(FRAME_LEN);
    end

    fdpn_frame_ram u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (in_accept),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_sample),
        .i_rd_en   (in_accept && info.ready),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // num = N * x - S, from the stored sample in the cycle after the read
    always_comb begin
        n_num = N_NUM * {{(NUM_W-SMP_W){rd_data[SMP_W-1]}}, rd_data}
              - {{(NUM_W-SUM_W){r_sum[SUM_W-1]}}, r_sum};
    end

    fdpn_divider u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_num    (r_num),
        .i_den    (r_den),
        .o_done   (div_done),
        .o_result (div_result)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_accept && info.ready) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL:  n_state = ST_LOAD;
            ST_LOAD: n_state = ST_DIV;
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || !i_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_stall   = 1'b1;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            ST_IDLE: o_stall   = 1'b0;
            ST_MUL:  o_stall   = 1'b1;
            ST_LOAD: div_start = 1'b1;
            ST_DIV:  o_stall   = 1'b1;
            ST_OUT:  out_load  = !r_out_valid || !i_stall;
            default: o_stall   = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_sum  <= info.held_sum;
            r_den  <= N_DEN * DEN_W'(info.held_peak);
            r_last <= info.last;
        end
        if (r_state == ST_MUL) begin
            r_num <= n_num;
        end
        if (out_load) begin
            r_out_norm <= div_result;
            r_out_end  <= r_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_normalized = r_out_norm;
    assign o_frame_end  = r_out_end;

endmodule

// ===== rtl/fdpn_checker.sv =====
// Port-level checker for the normalize core, bound to the top level.
`include "frame_dc_removal_peak_normalize_core_macros.svh"

module fdpn_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_normalized,
    input logic        o_frame_end
);

    // a stalled output word holds
    `FDPN_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_normalized) && $stable(o_frame_end))

    // a new output word only comes while a sample is being worked on
    `FDPN_ASSERT_NOW(a_rise_busy, i_clk, i_rst_n, $rose(o_valid), $past(o_stall))

    // no word appears the cycle after a sample is taken
    `FDPN_ASSERT_NEXT(a_no_instant, i_clk, i_rst_n, i_valid && !o_stall, !$rose(o_valid))

endmodule

bind frame_dc_removal_peak_normalize_core fdpn_checker u_fdpn_checker (.*);
